[hdl/bpa_pkg.sv]
// Shared constants, codes and types of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

   localparam int PAGE_SLOTS_DEF = 32768;
   localparam int PAGE_BYTES_DEF = 4096;

   // Bitmap and summary memories are built from words of this many bits
   localparam int WORD_BITS = 64;
   localparam int WORD_AW   = 6;

   localparam int CSR_AW = 2;

   typedef enum logic [CSR_AW-1:0] {
      CSR_PAGE_COUNT  = 2'd0,
      CSR_REGION_BASE = 2'd1,
      CSR_MAP_OFFSET  = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK           = 2'd0,
      STAT_NO_FREE      = 2'd1,
      STAT_RANGE        = 2'd2,
      STAT_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_SUM,
      S_A_MAP,
      S_A_ADDR,
      S_F_SUB,
      S_F_CHK,
      S_F_RD,
      S_F_UPD,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

[hdl/bpa_first_zero.sv]
// Lowest-clear-bit finder used on the top vector, summary words and bitmap words.
`default_nettype none

module bpa_first_zero #(
   parameter int WIDTH = bpa_pkg::WORD_BITS,
   parameter int IW    = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
   input  wire logic [WIDTH-1:0] word,
   output logic                  found,
   output logic [IW-1:0]         index
);

   logic [WIDTH-1:0] clear_bits;
   logic [WIDTH-1:0] lowest;

   // Isolate the lowest clear bit as a one-hot vector
   assign clear_bits = ~word;
   assign lowest     = clear_bits & (~clear_bits + WIDTH'(1));
   assign found      = |clear_bits;

   // Encode: index bit j is the OR of every one-hot position whose bit j is set
   always_comb begin
      index = '0;
      for (int j = 0; j < IW; j++) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (((i >> j) & 1) == 1) begin
               index[j] = index[j] | lowest[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

[hdl/bitmap_page_allocator_core.sv]
// Top level of the first-fit bitmap page frame allocator.
`default_nettype none

// One used bit per page lives in a bitmap memory of 64-bit words; a summary
// memory holds one "word full" bit per bitmap word, and a flip-flop vector one
// "summary word full" bit per summary word, so an allocate finds the lowest free
// page with one summary read and one bitmap read. An allocate passes through the
// states A_SUM, A_MAP and A_ADDR and a free through F_SUB, F_CHK, F_RD and F_UPD
// before its result is loaded into the output register in RESP (a failed
// allocate or out-of-range free skips the later ones); the two memory reads in
// series and the 64-bit address arithmetic set these steps. Requests are handled
// one at a time; a new one is taken while the previous result still waits on
// rsp_ready. After reset a clearing pass writes every bitmap word, one a cycle,
// with req_ready low; configuration writes are taken throughout. PAGE_BYTES
// must be a power of two.
module bitmap_page_allocator_core #(
   parameter int PAGE_SLOTS = bpa_pkg::PAGE_SLOTS_DEF,
   parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_op,
   input  wire logic [63:0]               req_page_addr_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [63:0]                    rsp_page_addr_out,
   output logic [15:0]                    rsp_used_count,
   output logic [15:0]                    rsp_free_count,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [bpa_pkg::CSR_AW-1:0] csr_index,
   input  wire logic [63:0]               csr_wdata
);

   localparam int WB        = bpa_pkg::WORD_BITS;
   localparam int WA        = bpa_pkg::WORD_AW;
   localparam int MAP_DEPTH = (PAGE_SLOTS + WB - 1) / WB;
   localparam int SUM_DEPTH = (MAP_DEPTH + WB - 1) / WB;
   localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
   localparam int PIX_W     = MAP_AW + WA;
   localparam int NW        = ($clog2(PAGE_SLOTS + 1) > 16) ? $clog2(PAGE_SLOTS + 1) : 16;
   localparam int SHIFT     = $clog2(PAGE_BYTES);

   // Control state
   bpa_pkg::state_type     state_ff, state_in;
   logic [MAP_AW-1:0]      clr_ff, clr_in;
   logic [SUM_DEPTH-1:0]   top_full_ff, top_full_in;
   logic [15:0]            used_ff, used_in;
   logic [15:0]            page_count_ff;
   logic [63:0]            region_base_ff;
   logic [63:0]            map_offset_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [63:0]            base_sum_ff;
   logic [63:0]            work_ff, work_in;
   logic                   below_ff, below_in;
   logic [SUM_AW-1:0]      s_idx_ff, s_idx_in;
   logic [MAP_AW-1:0]      w_idx_ff, w_idx_in;
   logic [WA-1:0]          sbit_ff, sbit_in;
   logic [WA-1:0]          pbit_ff, pbit_in;
   bpa_pkg::status_type    status_ff, status_in;
   logic [1:0]             rsp_status_ff;
   logic [63:0]            rsp_addr_ff;
   logic [15:0]            rsp_used_ff;
   logic [15:0]            rsp_free_ff;

   // Memory ports
   logic [WB-1:0]          map_mem [MAP_DEPTH];
   logic [WB-1:0]          sum_mem [SUM_DEPTH];
   logic                   map_we, map_re, sum_we, sum_re;
   logic [MAP_AW-1:0]      map_waddr, map_raddr;
   logic [SUM_AW-1:0]      sum_waddr, sum_raddr;
   logic [WB-1:0]          map_wdata, sum_wdata, map_q, sum_q;

   // Finder outputs
   logic                   top_found, sum_found, map_found;
   logic [SUM_AW-1:0]      top_idx;
   logic [WA-1:0]          sum_bit, map_bit;

   logic                   req_accept;
   logic                   rsp_load;
   logic [31:0]            pc_ext;
   logic [NW-1:0]          eff_n;
   logic [SUM_AW+WA-1:0]   w_cat;
   logic                   w_oob;
   logic [PIX_W-1:0]       alloc_pix;
   logic                   alloc_fail;
   logic [WB-1:0]          map_set;
   logic [WB-1:0]          sum_set;
   logic                   free_range;
   logic [PIX_W-1:0]       free_pix;
   logic [SUM_AW+WA-1:0]   free_w_ext;
   logic                   page_used;

   bpa_first_zero #(.WIDTH(SUM_DEPTH), .IW(SUM_AW)) u_top_find (
      .word  (top_full_ff),
      .found (top_found),
      .index (top_idx)
   );

   bpa_first_zero #(.WIDTH(WB), .IW(WA)) u_sum_find (
      .word  (sum_q),
      .found (sum_found),
      .index (sum_bit)
   );

   bpa_first_zero #(.WIDTH(WB), .IW(WA)) u_map_find (
      .word  (map_q),
      .found (map_found),
      .index (map_bit)
   );

   assign req_ready  = (state_ff == bpa_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == bpa_pkg::S_RESP) && (!rsp_valid_ff || rsp_ready);

   assign pc_ext = 32'(page_count_ff);
   assign eff_n  = NW'((pc_ext > 32'(PAGE_SLOTS)) ? 32'(PAGE_SLOTS) : pc_ext);

   // Allocate path: word chosen from the summary, page chosen from that word
   assign w_cat      = {s_idx_ff, sum_bit};
   assign w_oob      = !sum_found || (32'(w_cat) >= 32'(MAP_DEPTH));
   assign alloc_pix  = {w_idx_ff, map_bit};
   assign alloc_fail = !map_found || (32'(alloc_pix) >= 32'(eff_n));
   assign map_set    = map_q | (WB'(1) << map_bit);
   assign sum_set    = sum_q | (WB'(1) << sbit_ff);

   // Free path: work_ff holds the byte distance from the region base here
   assign free_range = below_ff || ((work_ff >> SHIFT) >= 64'(eff_n));
   assign free_pix   = work_ff[SHIFT +: PIX_W];
   assign free_w_ext = (SUM_AW + WA)'(free_pix[PIX_W-1:WA]);
   assign page_used  = map_q[pbit_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpa_pkg::S_CLEAR: begin
            if (clr_ff == MAP_AW'(MAP_DEPTH - 1)) begin
               state_in = bpa_pkg::S_IDLE;
            end
         end
         bpa_pkg::S_IDLE: begin
            if (req_accept) begin
               if (bpa_pkg::op_type'(req_op) == bpa_pkg::OP_FREE) begin
                  state_in = bpa_pkg::S_F_SUB;
               end else if (top_found) begin
                  state_in = bpa_pkg::S_A_SUM;
               end else begin
                  state_in = bpa_pkg::S_RESP;
               end
            end
         end
         bpa_pkg::S_A_SUM:  state_in = w_oob ? bpa_pkg::S_RESP : bpa_pkg::S_A_MAP;
         bpa_pkg::S_A_MAP:  state_in = alloc_fail ? bpa_pkg::S_RESP : bpa_pkg::S_A_ADDR;
         bpa_pkg::S_A_ADDR: state_in = bpa_pkg::S_RESP;
         bpa_pkg::S_F_SUB:  state_in = bpa_pkg::S_F_CHK;
         bpa_pkg::S_F_CHK:  state_in = bpa_pkg::S_F_RD;
         bpa_pkg::S_F_RD:   state_in = free_range ? bpa_pkg::S_RESP : bpa_pkg::S_F_UPD;
         bpa_pkg::S_F_UPD:  state_in = bpa_pkg::S_RESP;
         bpa_pkg::S_RESP: begin
            if (rsp_load) begin
               state_in = bpa_pkg::S_IDLE;
            end
         end
         default:           state_in = bpa_pkg::S_CLEAR;
      endcase
   end

   // Memory controls and datapath
   always_comb begin
      map_we      = 1'b0;
      map_waddr   = w_idx_ff;
      map_wdata   = '0;
      map_re      = 1'b0;
      map_raddr   = w_idx_ff;
      sum_we      = 1'b0;
      sum_waddr   = s_idx_ff;
      sum_wdata   = '0;
      sum_re      = 1'b0;
      sum_raddr   = s_idx_ff;
      clr_in      = clr_ff;
      top_full_in = top_full_ff;
      used_in     = used_ff;
      work_in     = work_ff;
      below_in    = below_ff;
      s_idx_in    = s_idx_ff;
      w_idx_in    = w_idx_ff;
      sbit_in     = sbit_ff;
      pbit_in     = pbit_ff;
      status_in   = status_ff;
      unique case (state_ff)
         bpa_pkg::S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            sum_we    = (32'(clr_ff) < 32'(SUM_DEPTH));
            sum_waddr = SUM_AW'(clr_ff);
            clr_in    = clr_ff + MAP_AW'(1);
         end
         bpa_pkg::S_IDLE: begin
            if (req_accept) begin
               if (bpa_pkg::op_type'(req_op) == bpa_pkg::OP_FREE) begin
                  work_in = req_page_addr_in;
               end else if (top_found) begin
                  sum_re    = 1'b1;
                  sum_raddr = top_idx;
                  s_idx_in  = top_idx;
               end else begin
                  status_in = bpa_pkg::STAT_NO_FREE;
                  work_in   = '0;
               end
            end
         end
         bpa_pkg::S_A_SUM: begin
            if (w_oob) begin
               status_in = bpa_pkg::STAT_NO_FREE;
               work_in   = '0;
            end else begin
               map_re    = 1'b1;
               map_raddr = MAP_AW'(w_cat);
               w_idx_in  = MAP_AW'(w_cat);
               sbit_in   = sum_bit;
            end
         end
         bpa_pkg::S_A_MAP: begin
            if (alloc_fail) begin
               status_in = bpa_pkg::STAT_NO_FREE;
               work_in   = '0;
            end else begin
               map_we    = 1'b1;
               map_wdata = map_set;
               // Propagate fullness up the summary levels
               if (&map_set) begin
                  sum_we    = 1'b1;
                  sum_wdata = sum_set;
                  if (&sum_set) begin
                     top_full_in[s_idx_ff] = 1'b1;
                  end
               end
               used_in   = used_ff + 16'd1;
               status_in = bpa_pkg::STAT_OK;
               work_in   = 64'(alloc_pix) << SHIFT;
            end
         end
         bpa_pkg::S_A_ADDR: begin
            work_in = base_sum_ff + work_ff;
         end
         bpa_pkg::S_F_SUB: begin
            work_in = work_ff - map_offset_ff;
         end
         bpa_pkg::S_F_CHK: begin
            below_in = (work_ff < region_base_ff);
            work_in  = work_ff - region_base_ff;
         end
         bpa_pkg::S_F_RD: begin
            work_in = '0;
            if (free_range) begin
               status_in = bpa_pkg::STAT_RANGE;
            end else begin
               map_re    = 1'b1;
               map_raddr = free_pix[PIX_W-1:WA];
               sum_re    = 1'b1;
               sum_raddr = free_w_ext[WA +: SUM_AW];
               w_idx_in  = free_pix[PIX_W-1:WA];
               s_idx_in  = free_w_ext[WA +: SUM_AW];
               sbit_in   = free_w_ext[WA-1:0];
               pbit_in   = free_pix[WA-1:0];
            end
         end
         bpa_pkg::S_F_UPD: begin
            if (!page_used) begin
               status_in = bpa_pkg::STAT_ALREADY_FREE;
            end else begin
               map_we                = 1'b1;
               map_wdata             = map_q & ~(WB'(1) << pbit_ff);
               sum_we                = 1'b1;
               sum_wdata             = sum_q & ~(WB'(1) << sbit_ff);
               top_full_in[s_idx_ff] = 1'b0;
               used_in               = used_ff - 16'd1;
               status_in             = bpa_pkg::STAT_OK;
            end
         end
         bpa_pkg::S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: drop on handshake, load when the slot is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bpa_pkg::S_CLEAR;
         clr_ff         <= '0;
         top_full_ff    <= '0;
         used_ff        <= '0;
         page_count_ff  <= '0;
         region_base_ff <= '0;
         map_offset_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_full_ff  <= top_full_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (bpa_pkg::csr_index_type'(csr_index))
               bpa_pkg::CSR_PAGE_COUNT:  page_count_ff  <= csr_wdata[15:0];
               bpa_pkg::CSR_REGION_BASE: region_base_ff <= csr_wdata;
               bpa_pkg::CSR_MAP_OFFSET:  map_offset_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      base_sum_ff <= region_base_ff + map_offset_ff;
      work_ff     <= work_in;
      below_ff    <= below_in;
      s_idx_ff    <= s_idx_in;
      w_idx_ff    <= w_idx_in;
      sbit_ff     <= sbit_in;
      pbit_ff     <= pbit_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= work_ff;
         rsp_used_ff   <= used_ff;
         rsp_free_ff   <= (eff_n > NW'(used_ff)) ? 16'(eff_n - NW'(used_ff)) : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      if (map_re) begin
         map_q <= map_mem[map_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      if (sum_re) begin
         sum_q <= sum_mem[sum_raddr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_page_addr_out = rsp_addr_ff;
   assign rsp_used_count    = rsp_used_ff;
   assign rsp_free_count    = rsp_free_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_used_only_on_update: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == bpa_pkg::S_A_MAP || state_ff == bpa_pkg::S_F_UPD)
      |=> (used_ff == $past(used_ff)))
      else $error("used count changed outside an update");

   a_map_write_state: assert property (@(posedge clock) disable iff (reset)
      map_we |-> (state_ff == bpa_pkg::S_CLEAR || state_ff == bpa_pkg::S_A_MAP
                  || state_ff == bpa_pkg::S_F_UPD))
      else $error("bitmap written outside clear or update");

   a_no_free_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != 2'(bpa_pkg::STAT_OK)) |-> (rsp_page_addr_out == 64'd0))
      else $error("failed request carries an address");

   a_resp_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_RESP && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == bpa_pkg::S_RESP))
      else $error("result overwrote an untaken result");

endmodule

`default_nettype wire

[test/bitmap_page_allocator_core_tb.sv]
// Self-checking testbench for the first-fit bitmap page allocator core.
module bitmap_page_allocator_core_tb;

   localparam int          PAGE_SLOTS   = bpa_pkg::PAGE_SLOTS_DEF;
   localparam int          PAGE_BYTES   = bpa_pkg::PAGE_BYTES_DEF;
   localparam int          ITEM_TARGET  = 900;
   localparam int          SETTLE_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   typedef struct packed {
      bpa_pkg::status_type status;
      logic [63:0]         page_addr;
      logic [15:0]         used_count;
      logic [15:0]         free_count;
   } page_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [63:0]         req_page_addr_in;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   logic [63:0]         rsp_page_addr_out;
   logic [15:0]         rsp_used_count;
   logic [15:0]         rsp_free_count;
   logic                csr_valid;
   logic                csr_ready;
   logic [bpa_pkg::CSR_AW-1:0] csr_index;
   logic [63:0]         csr_wdata;

   // allocator mirror: bitmap, used count and registers
   bit                  page_used [PAGE_SLOTS];
   logic [15:0]         taken_pages;
   logic [15:0]         cfg_page_count;
   logic [63:0]         cfg_region_base;
   logic [63:0]         cfg_map_offset;

   page_result_type     pending_results[$];
   page_result_type     want;
   int unsigned         mismatch_count;
   int unsigned         sent_count;
   int unsigned         cycle_count;
   int unsigned         stall_request;
   int unsigned         stall_left;
   int unsigned         ready_pick;
   bit                  no_idle;

   bitmap_page_allocator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_page_addr_in  (req_page_addr_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_page_addr_out (rsp_page_addr_out),
      .rsp_used_count    (rsp_used_count),
      .rsp_free_count    (rsp_free_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int unsigned effective_pages();
      return (cfg_page_count > PAGE_SLOTS) ? PAGE_SLOTS : int'(cfg_page_count);
   endfunction

   function automatic logic [63:0] mapped_addr(int unsigned index, int unsigned offset);
      return cfg_map_offset + cfg_region_base + 64'(index) * PAGE_BYTES + 64'(offset);
   endfunction

   function automatic logic [63:0] random64();
      return {$urandom, $urandom};
   endfunction

   // Work out one result from the mirror and queue it
   task automatic predict_result(bpa_pkg::op_type op, logic [63:0] addr_in);
      page_result_type res;
      int unsigned  eff;
      int unsigned  idx;
      logic [63:0]  phys;
      logic [63:0]  page_idx;
      eff = effective_pages();
      res.page_addr = '0;
      if (op == bpa_pkg::OP_ALLOC) begin
         idx = 0;
         while (idx < eff && page_used[idx]) idx++;
         if (idx < eff) begin
            page_used[idx] = 1'b1;
            taken_pages    = taken_pages + 16'd1;
            res.status     = bpa_pkg::STAT_OK;
            res.page_addr  = mapped_addr(idx, 0);
         end else begin
            res.status = bpa_pkg::STAT_NO_FREE;
         end
      end else begin
         phys     = addr_in - cfg_map_offset;
         page_idx = (phys - cfg_region_base) / PAGE_BYTES;
         if (phys < cfg_region_base || page_idx >= 64'(eff)) begin
            res.status = bpa_pkg::STAT_RANGE;
         end else if (!page_used[page_idx]) begin
            res.status = bpa_pkg::STAT_ALREADY_FREE;
         end else begin
            page_used[page_idx] = 1'b0;
            taken_pages         = taken_pages - 16'd1;
            res.status          = bpa_pkg::STAT_OK;
         end
      end
      res.used_count = taken_pages;
      res.free_count = (eff > taken_pages) ? 16'(eff - taken_pages) : 16'd0;
      pending_results.push_back(res);
   endtask

   task automatic note_mismatch(string what, logic [63:0] expected, logic [63:0] actual);
      if (mismatch_count < 10)
         $display("mismatch in %s: expected %h, got %h", what, expected, actual);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("result with nothing pending", '0, rsp_page_addr_out);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", 64'(want.status), 64'(rsp_status));
            if (rsp_page_addr_out !== want.page_addr)
               note_mismatch("page_addr_out", want.page_addr, rsp_page_addr_out);
            if (rsp_used_count !== want.used_count)
               note_mismatch("used_count", 64'(want.used_count), 64'(rsp_used_count));
            if (rsp_free_count !== want.free_count)
               note_mismatch("free_count", 64'(want.free_count), 64'(rsp_free_count));
         end
      end
   end

   // Result side: random stalls, plus a long hold when one is requested
   always @(posedge clock) begin
      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 80) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            stall_left = (ready_pick < 97) ? $urandom_range(0, 2) : $urandom_range(7, 39);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Leaves req_valid high; the caller sends again or calls wait_idle in the same step
   task automatic send_request(bpa_pkg::op_type op, logic [63:0] addr);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_page_addr_in <= addr;
      do @(posedge clock); while (!req_ready);
      predict_result(op, addr);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(logic [15:0] page_count, logic [63:0] base, logic [63:0] offset);
      bpa_pkg::csr_index_type idx;
      for (int i = 0; i < 3; i++) begin
         idx = bpa_pkg::csr_index_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         case (idx)
            bpa_pkg::CSR_PAGE_COUNT:  csr_wdata <= 64'(page_count);
            bpa_pkg::CSR_REGION_BASE: csr_wdata <= base;
            default:                  csr_wdata <= offset;
         endcase
         do @(posedge clock); while (!csr_ready);
         case (idx)
            bpa_pkg::CSR_PAGE_COUNT:  cfg_page_count  = page_count;
            bpa_pkg::CSR_REGION_BASE: cfg_region_base = base;
            default:                  cfg_map_offset  = offset;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Registers at reset: no pages managed, so nothing to allocate or free
   task automatic test_reset_defaults();
      send_request(bpa_pkg::OP_ALLOC, random64());
      send_request(bpa_pkg::OP_FREE, 64'd0);
      wait_idle();
   endtask

   // Region near the top of the address space so mapped addresses wrap
   task automatic test_small_region();
      load_config(16'd3, 64'hFFFF_FFFF_FFFF_E000, 64'h0000_0000_0000_3000);
      repeat (4) send_request(bpa_pkg::OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(bpa_pkg::OP_FREE, mapped_addr(1, 12'hFFF));
      send_request(bpa_pkg::OP_FREE, mapped_addr(1, 0));
      send_request(bpa_pkg::OP_FREE, mapped_addr(0, 0) - 64'd1);
      send_request(bpa_pkg::OP_FREE, mapped_addr(3, 0));
      send_request(bpa_pkg::OP_FREE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(bpa_pkg::OP_FREE, 64'd0);
      send_request(bpa_pkg::OP_ALLOC, 64'd0);
      wait_idle();
   endtask

   // A lowered count: allocation stops at it and a free above it is out of range
   task automatic test_shrunk_count();
      load_config(16'd5, 64'h0000_0000_8000_0000, 64'hFFFF_8000_0000_0000);
      repeat (2) send_request(bpa_pkg::OP_ALLOC, random64());
      wait_idle();
      load_config(16'd2, cfg_region_base, cfg_map_offset);
      send_request(bpa_pkg::OP_ALLOC, random64());
      send_request(bpa_pkg::OP_FREE, mapped_addr(4, 0));
      send_request(bpa_pkg::OP_FREE, mapped_addr(0, 0));
      wait_idle();
      load_config(16'd5, cfg_region_base, cfg_map_offset);
      send_request(bpa_pkg::OP_ALLOC, random64());
      wait_idle();
   endtask

   task automatic test_oversized_count();
      load_config(16'hFFFF, 64'd0, 64'd0);
      repeat (2) send_request(bpa_pkg::OP_ALLOC, random64());
      send_request(bpa_pkg::OP_FREE, mapped_addr(PAGE_SLOTS - 1, 0));
      send_request(bpa_pkg::OP_FREE, mapped_addr(PAGE_SLOTS, 0));
      wait_idle();
   endtask

   // Hold the result side off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      load_config(16'd40, 64'h0000_0001_0000_0000, 64'h0000_0000_0010_0000);
      stall_request = 300;
      no_idle       = 1'b1;
      for (int i = 0; i < 20; i++) begin
         if (i % 4 == 3)
            send_request(bpa_pkg::OP_FREE, mapped_addr($urandom_range(0, 10), 0));
         else
            send_request(bpa_pkg::OP_ALLOC, random64());
      end
      wait_idle();
      no_idle = 1'b0;
   endtask

   function automatic logic [63:0] pick_wide();
      case ($urandom_range(0, 3))
         0:       return 64'd0;
         1:       return 64'hFFFF_FFFF_FFFF_FFFF;
         2:       return random64();
         default: return random64() & ~64'hFFF;
      endcase
   endfunction

   function automatic logic [63:0] pick_free_addr();
      int unsigned hi;
      int unsigned offset;
      if ($urandom_range(0, 99) < 15)
         return random64();
      // aim near the low pages, where first fit leaves the used ones
      hi = int'(taken_pages) + 3;
      if (hi > effective_pages())
         hi = effective_pages();
      offset = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAGE_BYTES - 1) : 0;
      return mapped_addr($urandom_range(0, hi), offset);
   endfunction

   task automatic test_random_traffic();
      logic [15:0] page_count;
      int unsigned phase_len;
      while (sent_count < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0:       page_count = 16'd1;
            1:       page_count = 16'($urandom_range(2, 16));
            2:       page_count = 16'($urandom_range(17, 130));
            3:       page_count = 16'd64;
            4:       page_count = 16'd0;
            5:       page_count = 16'(PAGE_SLOTS);
            6:       page_count = 16'($urandom_range(PAGE_SLOTS + 1, 65535));
            default: page_count = 16'hFFFF;
         endcase
         load_config(page_count, pick_wide(), pick_wide());
         no_idle   = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(60, 120);
         for (int n = 0; n < phase_len && sent_count < ITEM_TARGET; n++) begin
            if ($urandom_range(0, 99) < 55)
               send_request(bpa_pkg::OP_ALLOC, random64());
            else
               send_request(bpa_pkg::OP_FREE, pick_free_addr());
         end
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = bpa_pkg::OP_ALLOC;
      req_page_addr_in = '0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = bpa_pkg::CSR_PAGE_COUNT;
      csr_wdata        = '0;
      taken_pages      = '0;
      cfg_page_count   = '0;
      cfg_region_base  = '0;
      cfg_map_offset   = '0;
      mismatch_count   = 0;
      sent_count       = 0;
      cycle_count      = 0;
      stall_request    = 0;
      stall_left       = 0;
      no_idle          = 1'b0;
      foreach (page_used[i]) page_used[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_region();
      test_shrunk_count();
      test_oversized_count();
      test_backpressure();
      test_random_traffic();

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/bpa_pkg.sv
hdl/bpa_first_zero.sv
hdl/bitmap_page_allocator_core.sv
test/bitmap_page_allocator_core_tb.sv
